// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the elevator controller RTL. They expand to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge of clk_i while rst_ni is high.
`define FCFS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fcfs: assertion failed");
// Check that a condition never holds on a rising edge of clk_i.
`define FCFS_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("fcfs: forbidden condition seen");
`else
`define FCFS_ASSERT(lbl, prop)
`define FCFS_ASSERT_NEVER(lbl, expr)
`endif

`endif

// ===== rtl/fcfs_pkg.sv =====
// ----------------------------------------------------------------------------
// fcfs_pkg
// Sizes, codes and types of the first-come-first-served elevator controller.
// ----------------------------------------------------------------------------
package fcfs_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned FLOOR_W  = 8;
  localparam int unsigned PERSON_W = 16;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned ENTRY_W  = PERSON_W + 2 * FLOOR_W;

  // A tick causes at most three events: floor report, pickup, drop-off.
  localparam int unsigned MAX_EV = 3;
  localparam int unsigned EVN_W  = 2;

  localparam logic [FLOOR_W-1:0] TOP_FLOOR_RST = 8'd15;

  // Input operation codes.
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    EV_ACCEPT = 3'd0,
    EV_REJECT = 3'd1,
    EV_FLOOR  = 3'd2,
    EV_PICKUP = 3'd3,
    EV_DROP   = 3'd4
  } event_kind_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_TO_SRC = 2'd1,
    PH_TO_DST = 2'd2
  } phase_e;

  typedef struct packed {
    event_kind_e         kind;
    logic [PERSON_W-1:0] person;
    logic [FLOOR_W-1:0]  floor;
    logic                last;
  } event_t;

  typedef struct packed {
    logic [PERSON_W-1:0] person;
    logic [FLOOR_W-1:0]  src;
    logic [FLOOR_W-1:0]  dst;
  } entry_t;

endpackage

// ===== rtl/fcfs_elevator_controller.sv =====
// ----------------------------------------------------------------------------
// fcfs_elevator_controller
// First-come-first-served elevator controller with a RAM-backed ride queue.
// ----------------------------------------------------------------------------
// Usage: send ride requests (op = 0) and ticks (op = 1) on the input
// channel. A request yields one item, accepted or rejected; it is rejected
// when the queue is full or either floor lies above top_floor. A tick yields
// zero to three items: when the car is idle the oldest request is popped,
// a pickup or drop-off due at the current floor is reported, and otherwise
// the car moves one floor and reports the floor it reaches plus any pickup
// or drop-off there. The last item of each input carries last = 1.
// Flow: one item is worked on at a time. A request is handled in S_IDLE, a
// tick of a moving car passes through S_RESOLVE, and a tick that pops the
// queue passes through S_POP and then S_RESOLVE, since the queue RAM read
// is registered. The results then leave a three-entry event buffer one per
// cycle through the output register while the receiver is ready, and the
// next item is taken once the buffer is empty, even while the final result
// still sits in the output register. A tick of an idle car with an empty
// queue yields no result. top_floor is written through cfg_we_i / cfg_data_i;
// the user must write it only while idle: the block does not enforce it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcfs_elevator_controller import fcfs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [FLOOR_W-1:0]  cfg_data_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                op_i,
  input  logic [PERSON_W-1:0] person_id_i,
  input  logic [FLOOR_W-1:0]  source_floor_i,
  input  logic [FLOOR_W-1:0]  destination_floor_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [KIND_W-1:0]   event_kind_o,
  output logic [PERSON_W-1:0] event_person_o,
  output logic [FLOOR_W-1:0]  event_floor_o,
  output logic                last_o
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_POP     = 2'd1;
  localparam logic [1:0] S_RESOLVE = 2'd2;

  // Control state
  logic [1:0]          state_q, state_d;
  logic [FLOOR_W-1:0]  top_floor_q, top_floor_d;
  logic [QIDX_W-1:0]   head_q, head_d;
  logic [QIDX_W-1:0]   tail_q, tail_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [FLOOR_W-1:0]  car_floor_q, car_floor_d;
  phase_e              phase_q, phase_d;
  logic [PERSON_W-1:0] act_person_q, act_person_d;
  logic [FLOOR_W-1:0]  act_src_q, act_src_d;
  logic [FLOOR_W-1:0]  act_dst_q, act_dst_d;
  logic [EVN_W-1:0]    ev_n_q, ev_n_d;
  logic                out_valid_q, out_valid_d;

  // Payload
  event_t ev_q [MAX_EV];
  event_t ev_d [MAX_EV];
  event_t out_q, out_d;

  // Queue RAM
  logic   ram_we, ram_re;
  entry_t ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  // Resolve results
  event_t           res_ev [MAX_EV];
  logic [EVN_W-1:0] res_n;
  phase_e           res_phase;
  logic [FLOOR_W-1:0] res_floor;

  logic in_fire, out_load, queue_full, reject;

  assign in_ready_o = (state_q == S_IDLE) && (ev_n_q == '0);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (ev_n_q != '0) && (!out_valid_q || out_ready_i);
  assign queue_full = (count_q == CNT_W'(QUEUE_DEPTH));
  assign reject     = queue_full || (source_floor_i > top_floor_q)
                      || (destination_floor_i > top_floor_q);

  assign ram_we    = in_fire && (op_i == OP_REQUEST) && !reject;
  assign ram_wdata = '{person: person_id_i, src: source_floor_i, dst: destination_floor_i};
  assign ram_re    = in_fire && (op_i != OP_REQUEST) && (phase_q == PH_IDLE)
                     && (count_q != '0);
  assign ram_rdata = entry_t'(ram_rdata_raw);

  fcfs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata_raw)
  );

  // Resolve one tick of an active ride: pickup/drop-off here, else move
  // one floor and resolve again at the new floor.
  always_comb begin
    phase_e             ph;
    logic [FLOOR_W-1:0] fl;
    logic [FLOOR_W-1:0] target;
    logic [EVN_W-1:0]   n;
    ph = phase_q;
    fl = car_floor_q;
    n  = '0;
    target = '0;
    for (int i = 0; i < MAX_EV; i++) begin
      res_ev[i] = '{kind: EV_FLOOR, person: '0, floor: '0, last: 1'b0};
    end
    if (ph == PH_TO_SRC && fl == act_src_q) begin
      res_ev[n] = '{kind: EV_PICKUP, person: act_person_q, floor: act_src_q, last: 1'b0};
      n  = n + 1'b1;
      ph = PH_TO_DST;
    end
    if (ph == PH_TO_DST && fl == act_dst_q) begin
      res_ev[n] = '{kind: EV_DROP, person: act_person_q, floor: act_dst_q, last: 1'b0};
      n  = n + 1'b1;
      ph = PH_IDLE;
    end
    if (n == '0 && ph != PH_IDLE) begin
      target = (ph == PH_TO_SRC) ? act_src_q : act_dst_q;
      fl = (target < fl) ? fl - 1'b1 : fl + 1'b1;
      res_ev[n] = '{kind: EV_FLOOR, person: '0, floor: fl, last: 1'b0};
      n = n + 1'b1;
      if (ph == PH_TO_SRC && fl == act_src_q) begin
        res_ev[n] = '{kind: EV_PICKUP, person: act_person_q, floor: act_src_q, last: 1'b0};
        n  = n + 1'b1;
        ph = PH_TO_DST;
      end
      if (ph == PH_TO_DST && fl == act_dst_q) begin
        res_ev[n] = '{kind: EV_DROP, person: act_person_q, floor: act_dst_q, last: 1'b0};
        n  = n + 1'b1;
        ph = PH_IDLE;
      end
    end
    // Mark the final event of this tick.
    for (int i = 0; i < MAX_EV; i++) begin
      res_ev[i].last = (EVN_W'(i) == n - 1'b1);
    end
    res_n     = n;
    res_phase = ph;
    res_floor = fl;
  end

  // Next-state logic
  always_comb begin
    state_d      = state_q;
    top_floor_d  = top_floor_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    car_floor_d  = car_floor_q;
    phase_d      = phase_q;
    act_person_d = act_person_q;
    act_src_d    = act_src_q;
    act_dst_d    = act_dst_q;
    ev_n_d       = ev_n_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    for (int i = 0; i < MAX_EV; i++) begin
      ev_d[i] = ev_q[i];
    end

    if (cfg_we_i) begin
      top_floor_d = cfg_data_i;
    end

    // Drain the event buffer into the output register, oldest first.
    if (out_load) begin
      out_d       = ev_q[0];
      out_valid_d = 1'b1;
      for (int i = 0; i < MAX_EV - 1; i++) begin
        ev_d[i] = ev_q[i+1];
      end
      ev_n_d = ev_n_q - 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (op_i == OP_REQUEST) begin
            ev_d[0] = '{kind: reject ? EV_REJECT : EV_ACCEPT, person: person_id_i,
                        floor: source_floor_i, last: 1'b1};
            ev_n_d  = EVN_W'(1);
            if (!reject) begin
              tail_d  = (tail_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
              count_d = count_q + 1'b1;
            end
          end else if (phase_q != PH_IDLE) begin
            state_d = S_RESOLVE;
          end else if (count_q != '0) begin
            state_d = S_POP;
          end
          // An idle tick with an empty queue produces nothing.
        end
      end
      S_POP: begin
        // Load the oldest ride from the RAM read issued at accept.
        act_person_d = ram_rdata.person;
        act_src_d    = ram_rdata.src;
        act_dst_d    = ram_rdata.dst;
        head_d       = (head_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
        count_d      = count_q - 1'b1;
        phase_d      = PH_TO_SRC;
        state_d      = S_RESOLVE;
      end
      S_RESOLVE: begin
        for (int i = 0; i < MAX_EV; i++) begin
          ev_d[i] = res_ev[i];
        end
        ev_n_d      = res_n;
        phase_d     = res_phase;
        car_floor_d = res_floor;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      top_floor_q  <= TOP_FLOOR_RST;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      car_floor_q  <= '0;
      phase_q      <= PH_IDLE;
      act_person_q <= '0;
      act_src_q    <= '0;
      act_dst_q    <= '0;
      ev_n_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      top_floor_q  <= top_floor_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      car_floor_q  <= car_floor_d;
      phase_q      <= phase_d;
      act_person_q <= act_person_d;
      act_src_q    <= act_src_d;
      act_dst_q    <= act_dst_d;
      ev_n_q       <= ev_n_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    for (int i = 0; i < MAX_EV; i++) begin
      ev_q[i] <= ev_d[i];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = out_q.kind;
  assign event_person_o = out_q.person;
  assign event_floor_o  = out_q.floor;
  assign last_o         = out_q.last;

  // Assertions
  `FCFS_ASSERT(a_count_bound, count_q <= CNT_W'(QUEUE_DEPTH))
  `FCFS_ASSERT(a_ready_empty_buf, in_ready_o |-> (ev_n_q == '0))
  `FCFS_ASSERT(a_pop_then_resolve, (state_q == S_POP) |=> (state_q == S_RESOLVE))
  `FCFS_ASSERT(a_pop_nonempty, (state_q == S_POP) |-> (count_q != '0))
  `FCFS_ASSERT_NEVER(a_resolve_active, (state_q == S_RESOLVE) && (phase_q == PH_IDLE))

endmodule

// ===== rtl/fcfs_ram.sv =====
// ----------------------------------------------------------------------------
// fcfs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fcfs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
